// ----- hw/rtl/icymd_pkg.sv -----
// ----------------------------------------------------------------------------
// ICY metadata demux package
// Shared sizes, operation codes and the control and status records that pass
// between the demultiplexer and the title scanner.
// ----------------------------------------------------------------------------
package icymd_pkg;

    localparam int TITLE_BYTES = 160;
    localparam int LEN_SCALE   = 16;
    localparam int LEN_SHIFT   = $clog2(LEN_SCALE);
    localparam int TAG_LEN     = 13;

    localparam int POS_W       = 12;
    localparam int BANK_IDX_W  = $clog2(TITLE_BYTES);
    localparam int MEM_DEPTH   = 2 * TITLE_BYTES;
    localparam int MEM_AW      = $clog2(MEM_DEPTH);

    localparam logic [7:0] CH_QUOTE = 8'h27;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_S     = 8'h53;

    typedef enum logic [1:0] {
        OP_STREAM = 2'd0,
        OP_RESYNC = 2'd1,
        OP_READ   = 2'd2,
        OP_CLEAR  = 2'd3
    } op_t;

    typedef struct packed {
        logic       scan;
        logic       clear;
        logic [7:0] data;
    } scan_ctl_t;

    typedef struct packed {
        logic                  in_title;
        logic [7:0]            commit_len;
        logic                  wr_en;
        logic [BANK_IDX_W-1:0] wr_pos;
        logic [7:0]            wr_data;
    } scan_stat_t;

endpackage

// ----- hw/rtl/icy_metadata_demux_title_extract_unit.sv -----
// ----------------------------------------------------------------------------
// ICY metadata demux with title extraction
// Splits an ICY radio byte stream into music bytes and metadata, captures the
// stream title into a double-buffered store and serves title reads.
//
// The s_ channel carries one transaction per item: an operation in s_tuser
// (stream byte, resync, read title character, clear title) with the stream
// byte and read index in s_tdata. Every accepted transaction yields exactly
// one result transaction on the m_ channel, in order. The result holds the
// music flag and the title-update flag in m_tuser, and the music byte, the
// title sequence count, the committed title length and the read character
// in m_tdata. The music interval is written through cfg_wr_en/cfg_wr_data;
// the user must do so only while the block is idle; the block does not enforce it.
//
// An item is accepted into an input register and processed as it moves on
// into a result register. One item is accepted every cycle while the
// receiver keeps up; the single write port and single registered read port
// of the title store serve one item per cycle. When the receiver stalls,
// the result register holds and one more item waits in the input register
// before s_tready drops.
// Reset empties both registers, selects the music phase and clears the title
// length and sequence count; there is no clearing pass over the title store.
// ----------------------------------------------------------------------------
module icy_metadata_demux_title_extract_unit
    import icymd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,

    input  logic        s_tvalid,
    output logic        s_tready,
    // s_tdata fields from bit 0: data_byte[7:0], read_index[15:8].
    input  logic [15:0] s_tdata,
    // s_tuser fields from bit 0: opcode[1:0].
    input  logic [1:0]  s_tuser,

    output logic        m_tvalid,
    input  logic        m_tready,
    // m_tdata fields from bit 0: music_byte[7:0], title_seq[39:8],
    // title_length[47:40], read_char[55:48].
    output logic [55:0] m_tdata,
    // m_tuser fields from bit 0: music_valid[0], title_updated[1].
    output logic [1:0]  m_tuser
);

    typedef enum logic [2:0] {
        PH_MUSIC = 3'b001,
        PH_LEN   = 3'b010,
        PH_META  = 3'b100
    } phase_t;

    logic [15:0]       meta_interval_reg;

    logic              in_valid_reg;
    op_t               in_op_reg;
    logic [7:0]        in_byte_reg;
    logic [7:0]        in_idx_reg;

    logic              out_valid_reg;
    logic              music_valid_reg, music_valid_next;
    logic [7:0]        music_byte_reg,  music_byte_next;
    logic              updated_reg,     updated_next;
    logic              rd_hit_reg,      rd_hit_next;
    logic [7:0]        rd_data_reg;

    phase_t            phase_reg,       phase_next;
    logic [15:0]       music_left_reg,  music_left_next;
    logic [POS_W-1:0]  meta_total_reg,  meta_total_next;
    logic [POS_W-1:0]  meta_count_reg,  meta_count_next;
    logic [POS_W-1:0]  meta_count_inc;
    logic              bank_reg,        bank_next;
    logic [7:0]        length_reg,      length_next;
    logic [31:0]       seq_reg,         seq_next;

    logic              advance;
    logic              take_len;
    logic              rd_en;
    logic [MEM_AW-1:0] rd_addr;
    logic [MEM_AW-1:0] wr_addr;
    scan_ctl_t         scan_ctl;
    scan_stat_t        scan_stat;

    logic [7:0]        title_mem [0:MEM_DEPTH-1];

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    icymd_title_scan u_scan (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (scan_ctl),
        .stat  (scan_stat)
    );

    always_comb
    begin
        phase_next       = phase_reg;
        music_left_next  = music_left_reg;
        meta_total_next  = meta_total_reg;
        meta_count_next  = meta_count_reg;
        meta_count_inc   = meta_count_reg + POS_W'(1);
        bank_next        = bank_reg;
        length_next      = length_reg;
        seq_next         = seq_reg;
        music_valid_next = 1'b0;
        music_byte_next  = 8'h00;
        updated_next     = 1'b0;
        rd_hit_next      = 1'b0;
        rd_en            = 1'b0;
        take_len         = 1'b0;
        scan_ctl.scan    = 1'b0;
        scan_ctl.clear   = 1'b0;
        scan_ctl.data    = in_byte_reg;

        if (advance)
        begin
            unique case (in_op_reg)
                OP_STREAM:
                begin
                    if (meta_interval_reg == 16'd0)
                    begin
                        music_valid_next = 1'b1;
                        music_byte_next  = in_byte_reg;
                    end
                    else
                    begin
                        unique case (phase_reg)
                            PH_LEN:
                            begin
                                take_len = 1'b1;
                            end
                            PH_META:
                            begin
                                scan_ctl.scan   = 1'b1;
                                meta_count_next = meta_count_inc;
                                if (meta_count_inc >= meta_total_reg)
                                begin
                                    scan_ctl.clear  = 1'b1;
                                    phase_next      = PH_MUSIC;
                                    music_left_next = meta_interval_reg;
                                    if (scan_stat.in_title)
                                    begin
                                        updated_next = 1'b1;
                                        bank_next    = !bank_reg;
                                        length_next  = scan_stat.commit_len;
                                        seq_next     = seq_reg + 32'd1;
                                    end
                                end
                            end
                            default:
                            begin
                                if (music_left_reg != 16'd0)
                                begin
                                    music_valid_next = 1'b1;
                                    music_byte_next  = in_byte_reg;
                                    music_left_next  = music_left_reg - 16'd1;
                                    phase_next       = (music_left_reg == 16'd1) ? PH_LEN
                                                                                 : PH_MUSIC;
                                end
                                else
                                begin
                                    take_len = 1'b1;
                                end
                            end
                        endcase

                        if (take_len)
                        begin
                            meta_total_next = POS_W'({in_byte_reg, {LEN_SHIFT{1'b0}}});
                            meta_count_next = '0;
                            scan_ctl.clear  = 1'b1;
                            if (in_byte_reg == 8'h00)
                            begin
                                phase_next      = PH_MUSIC;
                                music_left_next = meta_interval_reg;
                            end
                            else
                            begin
                                phase_next = PH_META;
                            end
                        end
                    end
                end
                OP_RESYNC:
                begin
                    phase_next      = PH_MUSIC;
                    music_left_next = meta_interval_reg;
                    meta_total_next = '0;
                    meta_count_next = '0;
                    scan_ctl.clear  = 1'b1;
                end
                OP_READ:
                begin
                    rd_en       = 1'b1;
                    rd_hit_next = (in_idx_reg < length_reg);
                end
                OP_CLEAR:
                begin
                    length_next  = 8'h00;
                    seq_next     = seq_reg + 32'd1;
                    updated_next = 1'b1;
                end
                default:
                begin
                    updated_next = 1'b0;
                end
            endcase
        end
    end

    assign rd_addr = MEM_AW'(in_idx_reg)
                   + (bank_reg ? MEM_AW'(TITLE_BYTES) : MEM_AW'(0));
    assign wr_addr = MEM_AW'(scan_stat.wr_pos)
                   + (bank_reg ? MEM_AW'(0) : MEM_AW'(TITLE_BYTES));

    always_ff @(posedge clk)
    begin
        if (scan_stat.wr_en)
        begin
            title_mem[wr_addr] <= scan_stat.wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= title_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_op_reg   <= op_t'(s_tuser);
            in_byte_reg <= s_tdata[7:0];
            in_idx_reg  <= s_tdata[15:8];
        end
        if (advance)
        begin
            music_byte_reg <= music_byte_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            meta_interval_reg <= 16'd0;
            in_valid_reg      <= 1'b0;
            out_valid_reg     <= 1'b0;
            music_valid_reg   <= 1'b0;
            updated_reg       <= 1'b0;
            rd_hit_reg        <= 1'b0;
            phase_reg         <= PH_MUSIC;
            music_left_reg    <= 16'd0;
            meta_total_reg    <= '0;
            meta_count_reg    <= '0;
            bank_reg          <= 1'b0;
            length_reg        <= 8'h00;
            seq_reg           <= 32'd0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                meta_interval_reg <= cfg_wr_data;
            end
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (advance)
            begin
                out_valid_reg   <= 1'b1;
                music_valid_reg <= music_valid_next;
                updated_reg     <= updated_next;
                rd_hit_reg      <= rd_hit_next;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            phase_reg      <= phase_next;
            music_left_reg <= music_left_next;
            meta_total_reg <= meta_total_next;
            meta_count_reg <= meta_count_next;
            bank_reg       <= bank_next;
            length_reg     <= length_next;
            seq_reg        <= seq_next;
        end
    end

    // The title length and sequence count change only when a transaction moves
    // into the result register, so they always match the presented result.
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = {updated_reg, music_valid_reg};
    assign m_tdata  = {(rd_hit_reg ? rd_data_reg : 8'h00), length_reg, seq_reg,
                       music_byte_reg};

    assert property (@(posedge clk) disable iff (!rst_n)
        !(advance && updated_next) |=> $stable(seq_reg))
        else $error("title sequence count changed without a title update");

    assert property (@(posedge clk) disable iff (!rst_n)
        !(music_valid_reg && updated_reg))
        else $error("music byte and title update in the same result");

    assert property (@(posedge clk) disable iff (!rst_n)
        length_reg <= 8'(TITLE_BYTES - 1))
        else $error("committed title length exceeds the title store");

    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> s_tready)
        else $error("input stalled while the result register is empty");

    assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(bank_reg) && $stable(length_reg))
        else $error("title bank or length changed without a transaction");

endmodule

// ----- hw/rtl/icymd_title_scan.sv -----
// ----------------------------------------------------------------------------
// ICY title scanner
// Finds the StreamTitle tag in a metadata block, tracks the title end markers
// and reports the title bytes to store and the length to commit.
// ----------------------------------------------------------------------------
module icymd_title_scan
    import icymd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  scan_ctl_t  ctl,
    output scan_stat_t stat
);

    logic [3:0]       match_pos_reg,   match_pos_scan,   match_pos_next;
    logic             in_title_reg,    in_title_scan,    in_title_next;
    logic             text_ended_reg,  text_ended_scan,  text_ended_next;
    logic             prev_quote_reg,  prev_quote_scan,  prev_quote_next;
    logic [POS_W-1:0] title_pos_reg,   title_pos_scan,   title_pos_next;
    logic             end_found_reg,   end_found_scan,   end_found_next;
    logic [POS_W-1:0] end_pos_reg,     end_pos_scan,     end_pos_next;
    logic             quote_found_reg, quote_found_scan, quote_found_next;
    logic [POS_W-1:0] last_quote_reg,  last_quote_scan,  last_quote_next;
    logic [POS_W-1:0] len_raw;
    logic             wr_hit;
    logic [3:0]       match_inc;

    function automatic logic [7:0] tag_char(input logic [3:0] pos);
        logic [7:0] c;
        case (pos)
            4'd0:    c = 8'h53;
            4'd1:    c = 8'h74;
            4'd2:    c = 8'h72;
            4'd3:    c = 8'h65;
            4'd4:    c = 8'h61;
            4'd5:    c = 8'h6D;
            4'd6:    c = 8'h54;
            4'd7:    c = 8'h69;
            4'd8:    c = 8'h74;
            4'd9:    c = 8'h6C;
            4'd10:   c = 8'h65;
            4'd11:   c = 8'h3D;
            4'd12:   c = 8'h27;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    always_comb
    begin
        match_pos_scan   = match_pos_reg;
        in_title_scan    = in_title_reg;
        text_ended_scan  = text_ended_reg;
        prev_quote_scan  = prev_quote_reg;
        title_pos_scan   = title_pos_reg;
        end_found_scan   = end_found_reg;
        end_pos_scan     = end_pos_reg;
        quote_found_scan = quote_found_reg;
        last_quote_scan  = last_quote_reg;
        wr_hit           = 1'b0;
        match_inc        = match_pos_reg + 4'd1;

        if (!text_ended_reg)
        begin
            if (ctl.data == 8'h00)
            begin
                text_ended_scan = 1'b1;
            end
            else if (!in_title_reg)
            begin
                if ((match_pos_reg < 4'(TAG_LEN)) && (ctl.data == tag_char(match_pos_reg)))
                begin
                    match_pos_scan = match_inc;
                end
                else
                begin
                    match_pos_scan = (ctl.data == CH_S) ? 4'd1 : 4'd0;
                end
                if (match_pos_scan >= 4'(TAG_LEN))
                begin
                    in_title_scan   = 1'b1;
                    match_pos_scan  = 4'd0;
                    prev_quote_scan = 1'b0;
                end
            end
            else if (!end_found_reg)
            begin
                if ((ctl.data == CH_SEMI) && prev_quote_reg)
                begin
                    end_found_scan = 1'b1;
                    end_pos_scan   = title_pos_reg - POS_W'(1);
                end
                else
                begin
                    if (ctl.data == CH_QUOTE)
                    begin
                        quote_found_scan = 1'b1;
                        last_quote_scan  = title_pos_reg;
                    end
                    prev_quote_scan = (ctl.data == CH_QUOTE);
                    wr_hit = (title_pos_reg < POS_W'(TITLE_BYTES - 1));
                    if (title_pos_reg != {POS_W{1'b1}})
                    begin
                        title_pos_scan = title_pos_reg + POS_W'(1);
                    end
                end
            end
        end

        if (end_found_scan)
        begin
            len_raw = end_pos_scan;
        end
        else if (quote_found_scan)
        begin
            len_raw = last_quote_scan;
        end
        else
        begin
            len_raw = title_pos_scan;
        end
        if (len_raw > POS_W'(TITLE_BYTES - 1))
        begin
            len_raw = POS_W'(TITLE_BYTES - 1);
        end

        stat.in_title   = in_title_scan;
        stat.commit_len = len_raw[7:0];
        stat.wr_en      = ctl.scan && wr_hit;
        stat.wr_pos     = title_pos_reg[BANK_IDX_W-1:0];
        stat.wr_data    = ctl.data;

        if (ctl.clear)
        begin
            match_pos_next   = '0;
            in_title_next    = 1'b0;
            text_ended_next  = 1'b0;
            prev_quote_next  = 1'b0;
            title_pos_next   = '0;
            end_found_next   = 1'b0;
            end_pos_next     = '0;
            quote_found_next = 1'b0;
            last_quote_next  = '0;
        end
        else if (ctl.scan)
        begin
            match_pos_next   = match_pos_scan;
            in_title_next    = in_title_scan;
            text_ended_next  = text_ended_scan;
            prev_quote_next  = prev_quote_scan;
            title_pos_next   = title_pos_scan;
            end_found_next   = end_found_scan;
            end_pos_next     = end_pos_scan;
            quote_found_next = quote_found_scan;
            last_quote_next  = last_quote_scan;
        end
        else
        begin
            match_pos_next   = match_pos_reg;
            in_title_next    = in_title_reg;
            text_ended_next  = text_ended_reg;
            prev_quote_next  = prev_quote_reg;
            title_pos_next   = title_pos_reg;
            end_found_next   = end_found_reg;
            end_pos_next     = end_pos_reg;
            quote_found_next = quote_found_reg;
            last_quote_next  = last_quote_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_pos_reg   <= '0;
            in_title_reg    <= 1'b0;
            text_ended_reg  <= 1'b0;
            prev_quote_reg  <= 1'b0;
            title_pos_reg   <= '0;
            end_found_reg   <= 1'b0;
            end_pos_reg     <= '0;
            quote_found_reg <= 1'b0;
            last_quote_reg  <= '0;
        end
        else
        begin
            match_pos_reg   <= match_pos_next;
            in_title_reg    <= in_title_next;
            text_ended_reg  <= text_ended_next;
            prev_quote_reg  <= prev_quote_next;
            title_pos_reg   <= title_pos_next;
            end_found_reg   <= end_found_next;
            end_pos_reg     <= end_pos_next;
            quote_found_reg <= quote_found_next;
            last_quote_reg  <= last_quote_next;
        end
    end

endmodule
